// ----- src/wpcb_pkg.sv -----
package wpcb_pkg;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_THICKNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM_HEIGHT = 2'd1;
	localparam logic [CFG_DATA_W-1:0] WALL_THICKNESS_RESET = 31'd65536;
	localparam logic [CFG_DATA_W-1:0] ROOM_HEIGHT_RESET = 31'd196608;

	// Depth of the job queue between front and back
	localparam int JOB_QUEUE_DEPTH = 4;

	// Box kind codes as they appear on the result
	localparam logic [1:0] BOX_WALL = 2'd0;
	localparam logic [1:0] BOX_FLOOR = 2'd1;
	localparam logic [1:0] BOX_CEILING = 2'd2;

	localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		JOB_WALL = 2'd0,
		JOB_FLOOR = 2'd1,
		JOB_CEIL = 2'd2,
		JOB_ERR = 2'd3
	} job_kind_t;

	// A wall uses (x0,y0)->(x1,y1); a slab carries the bounding box as min (x0,y0), max (x1,y1).
	typedef struct packed {
		job_kind_t kind;
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_push_t;

	// Saturate a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = COORD_MAX;
		end else if (v < -36'sd2147483648) begin
			r = COORD_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
		return {{4{v[31]}}, v};
	endfunction

endpackage

// ----- src/wall_polygon_collision_boxes.sv -----
// Turns a stream of polygon vertices (signed Q16.16, one per transaction, the final one
// flagged by last_vertex) into oriented collision boxes: one wall per edge from the second
// vertex on, then on the final vertex the closing wall, a floor and a ceiling slab (the
// ceiling carries last_box). A polygon of fewer than three vertices gives a single result
// with too_few_vertices and last_box set. A front stage accepts a vertex and queues up to
// four box jobs; the back end computes each wall serially: set-up and multiplies, a square
// root and four divisions, while a slab or error result goes straight to the output. A
// vertex is taken once the front has queued all jobs of the previous one, so the back end
// sets the sustained rate.
// Configuration registers may be written only while the block is idle.
module wall_polygon_collision_boxes #(
	parameter int QUEUE_DEPTH = wpcb_pkg::JOB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [wpcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wpcb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic last_vertex,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic signed [31:0] center_z,
	output logic signed [31:0] axis_a_x,
	output logic signed [31:0] axis_a_y,
	output logic signed [31:0] axis_b_x,
	output logic signed [31:0] axis_b_y,
	output logic signed [31:0] axis_c_z,
	output logic [1:0] box_kind,
	output logic last_box,
	output logic too_few_vertices
);
	import wpcb_pkg::*;

	logic [CFG_DATA_W-1:0] thickness_q, height_q;
	job_push_t push;
	logic queue_full, job_valid, job_pop;
	job_t job;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thickness_q <= WALL_THICKNESS_RESET;
			height_q <= ROOM_HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_WALL_THICKNESS) begin
				thickness_q <= cfg_data;
			end else if (cfg_index == REG_ROOM_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	wpcb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.push(push),
		.queue_full(queue_full)
	);

	wpcb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(queue_full),
		.pop_valid(job_valid),
		.pop_job(job),
		.pop(job_pop)
	);

	wpcb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.thickness(thickness_q),
		.height(height_q),
		.job_valid(job_valid),
		.job(job),
		.job_pop(job_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.axis_a_x(axis_a_x),
		.axis_a_y(axis_a_y),
		.axis_b_x(axis_b_x),
		.axis_b_y(axis_b_y),
		.axis_c_z(axis_c_z),
		.box_kind(box_kind),
		.last_box(last_box),
		.too_few_vertices(too_few_vertices)
	);

endmodule

// ----- src/wpcb_front.sv -----
module wpcb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic last_vertex,
	output wpcb_pkg::job_push_t push,
	input  logic queue_full
);
	import wpcb_pkg::*;

	// Pending jobs of the current vertex, lowest bit first
	localparam int P_ERR = 0;
	localparam int P_WALL = 1;
	localparam int P_CLOSE = 2;
	localparam int P_FLOOR = 3;
	localparam int P_CEIL = 4;

	logic signed [31:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic [1:0] seen_q;
	logic [4:0] pend_q;

	// Operands captured at the accepting transaction
	logic signed [31:0] cur_x_q, cur_y_q, old_x_q, old_y_q, fst_x_q, fst_y_q;
	logic signed [31:0] bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;

	logic accept;
	logic signed [31:0] nmin_x, nmin_y, nmax_x, nmax_y, nfirst_x, nfirst_y;
	logic [1:0] nseen;
	logic err;
	logic [4:0] grant;

	assign in_stall = |pend_q;
	assign accept = in_valid && !in_stall;

	// Running state as it stands after this vertex
	always_comb begin
		nmin_x = (vertex_x < min_x_q) ? vertex_x : min_x_q;
		nmin_y = (vertex_y < min_y_q) ? vertex_y : min_y_q;
		nmax_x = (vertex_x > max_x_q) ? vertex_x : max_x_q;
		nmax_y = (vertex_y > max_y_q) ? vertex_y : max_y_q;
		nfirst_x = (seen_q == 2'd0) ? vertex_x : first_x_q;
		nfirst_y = (seen_q == 2'd0) ? vertex_y : first_y_q;
		nseen = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
		err = last_vertex && (nseen != 2'd3);
	end

	// The lowest pending job goes out when the queue has room
	assign grant = pend_q & (~pend_q + 5'd1);

	always_comb begin
		push.valid = (|pend_q) && !queue_full;
		push.job.kind = JOB_WALL;
		push.job.x0 = old_x_q;
		push.job.y0 = old_y_q;
		push.job.x1 = cur_x_q;
		push.job.y1 = cur_y_q;
		priority if (grant[P_ERR]) begin
			push.job.kind = JOB_ERR;
		end else if (grant[P_CLOSE]) begin
			push.job.x0 = cur_x_q;
			push.job.y0 = cur_y_q;
			push.job.x1 = fst_x_q;
			push.job.y1 = fst_y_q;
		end else if (grant[P_FLOOR] || grant[P_CEIL]) begin
			push.job.kind = grant[P_FLOOR] ? JOB_FLOOR : JOB_CEIL;
			push.job.x0 = bmin_x_q;
			push.job.y0 = bmin_y_q;
			push.job.x1 = bmax_x_q;
			push.job.y1 = bmax_y_q;
		end
	end

	// Polygon state and pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			min_x_q <= COORD_MAX;
			min_y_q <= COORD_MAX;
			max_x_q <= COORD_MIN;
			max_y_q <= COORD_MIN;
			seen_q <= '0;
			pend_q <= '0;
		end else if (accept) begin
			if (last_vertex) begin
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q <= '0;
				prev_y_q <= '0;
				min_x_q <= COORD_MAX;
				min_y_q <= COORD_MAX;
				max_x_q <= COORD_MIN;
				max_y_q <= COORD_MIN;
				seen_q <= '0;
			end else begin
				first_x_q <= nfirst_x;
				first_y_q <= nfirst_y;
				prev_x_q <= vertex_x;
				prev_y_q <= vertex_y;
				min_x_q <= nmin_x;
				min_y_q <= nmin_y;
				max_x_q <= nmax_x;
				max_y_q <= nmax_y;
				seen_q <= nseen;
			end
			pend_q[P_ERR] <= err;
			pend_q[P_WALL] <= !err && (nseen != 2'd1);
			pend_q[P_CLOSE] <= last_vertex && !err;
			pend_q[P_FLOOR] <= last_vertex && !err;
			pend_q[P_CEIL] <= last_vertex && !err;
		end else if (push.valid) begin
			pend_q <= pend_q & ~grant;
		end
	end

	// Job operands
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= vertex_x;
			cur_y_q <= vertex_y;
			old_x_q <= prev_x_q;
			old_y_q <= prev_y_q;
			fst_x_q <= nfirst_x;
			fst_y_q <= nfirst_y;
			bmin_x_q <= nmin_x;
			bmin_y_q <= nmin_y;
			bmax_x_q <= nmax_x;
			bmax_y_q <= nmax_y;
		end
	end

endmodule

// ----- src/wpcb_queue.sv -----
module wpcb_queue #(
	parameter int DEPTH = wpcb_pkg::JOB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  wpcb_pkg::job_push_t push,
	output logic full,
	output logic pop_valid,
	output wpcb_pkg::job_t pop_job,
	input  logic pop
);
	import wpcb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job = entry_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push.valid && full))
		else $error("job pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !pop_valid))
		else $error("job popped from an empty queue");

endmodule

// ----- src/wpcb_back.sv -----
module wpcb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [wpcb_pkg::CFG_DATA_W-1:0] thickness,
	input  logic [wpcb_pkg::CFG_DATA_W-1:0] height,
	input  logic job_valid,
	input  wpcb_pkg::job_t job,
	output logic job_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic signed [31:0] center_z,
	output logic signed [31:0] axis_a_x,
	output logic signed [31:0] axis_a_y,
	output logic signed [31:0] axis_b_x,
	output logic signed [31:0] axis_b_y,
	output logic signed [31:0] axis_c_z,
	output logic [1:0] box_kind,
	output logic last_box,
	output logic too_few_vertices
);
	import wpcb_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_DIFF  = 10'b00_0000_0010,
		S_SQA   = 10'b00_0000_0100,
		S_SQB   = 10'b00_0000_1000,
		S_ROOT  = 10'b00_0001_0000,
		S_MULB  = 10'b00_0010_0000,
		S_MULA  = 10'b00_0100_0000,
		S_DLOAD = 10'b00_1000_0000,
		S_DIV   = 10'b01_0000_0000,
		S_EMIT  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	job_t job_q;
	logic signed [32:0] dx_q, dy_q;
	logic [30:0] a_q, b_q;
	logic [63:0] sq_q, rmd_q, root_q, bit_q;
	logic [31:0] len_q;
	logic [61:0] pa_q, pb_q;
	logic [31:0] quo_q [4];
	logic [1:0] div_idx_q;
	logic [33:0] dr_q;
	logic [31:0] dsh_q;
	logic [32:0] dd_q;
	logic [4:0] dcnt_q;
	logic out_valid_q;

	logic signed [32:0] dx, dy;
	logic [32:0] ax, ay;
	logic halve;
	logic [63:0] root_try;
	logic [62:0] num;
	logic [33:0] trial;
	logic ge;
	logic out_free;
	logic signed [35:0] hx, hy, bx, by, mx, my, tt;
	logic signed [31:0] r_cx, r_cy, r_cz, r_ax, r_ay, r_bx, r_by, r_cz_axis;
	logic [1:0] r_kind;
	logic r_last, r_err;

	assign out_free = !out_valid_q || !out_stall;
	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign out_valid = out_valid_q;

	// Edge vector and its magnitudes, halved when either would overflow 31 bits
	always_comb begin
		dx = {job_q.x1[31], job_q.x1} - {job_q.x0[31], job_q.x0};
		dy = {job_q.y1[31], job_q.y1} - {job_q.y0[31], job_q.y0};
		ax = dx[32] ? 33'(-dx) : 33'(dx);
		ay = dy[32] ? 33'(-dy) : 33'(dy);
		halve = ax[32] || ax[31] || ay[32] || ay[31];
	end

	// Square root step, divider dividend and divider step
	always_comb begin
		root_try = root_q + bit_q;
		num = 63'(div_idx_q[0] ? pa_q : pb_q)
			+ 63'(div_idx_q[1] ? len_q : (len_q >> 1));
		trial = {dr_q[32:0], dsh_q[31]};
		ge = (trial >= {1'b0, dd_q});
	end

	// Result fields for the job in hand
	always_comb begin
		tt = {5'd0, thickness};
		mx = sx36(job_q.x0) + sx36(job_q.x1);
		my = sx36(job_q.y0) + sx36(job_q.y1);
		hx = dy_q[32] ? -$signed({4'd0, quo_q[2]}) : $signed({4'd0, quo_q[2]});
		hy = dx_q[32] ? $signed({4'd0, quo_q[3]}) : -$signed({4'd0, quo_q[3]});
		bx = dy_q[32] ? $signed({4'd0, quo_q[0]}) : -$signed({4'd0, quo_q[0]});
		by = dx_q[32] ? -$signed({4'd0, quo_q[1]}) : $signed({4'd0, quo_q[1]});
		r_last = 1'b0;
		r_err = 1'b0;
		r_kind = BOX_WALL;
		r_cx = '0;
		r_cy = '0;
		r_cz = '0;
		r_ax = '0;
		r_ay = '0;
		r_bx = '0;
		r_by = '0;
		r_cz_axis = '0;
		unique case (job_q.kind)
			JOB_WALL: begin
				r_cx = sat32((mx >>> 1) + hx);
				r_cy = sat32((my >>> 1) + hy);
				r_cz = {2'd0, height[30:1]};
				r_ax = sat32({{3{dx_q[32]}}, dx_q});
				r_ay = sat32({{3{dy_q[32]}}, dy_q});
				r_bx = sat32(bx);
				r_by = sat32(by);
				r_cz_axis = {1'b0, height};
			end
			JOB_FLOOR, JOB_CEIL: begin
				r_cx = sat32(mx >>> 1);
				r_cy = sat32(my >>> 1);
				r_cz = (job_q.kind == JOB_FLOOR) ? sat32((-tt) >>> 1)
					: sat32({5'd0, height} + (tt >>> 1));
				r_ax = sat32(sx36(job_q.x1) - sx36(job_q.x0) + (tt <<< 1));
				r_by = sat32(sx36(job_q.y1) - sx36(job_q.y0) + (tt <<< 1));
				r_cz_axis = {1'b0, thickness};
				r_kind = (job_q.kind == JOB_FLOOR) ? BOX_FLOOR : BOX_CEILING;
				r_last = (job_q.kind == JOB_CEIL);
			end
			JOB_ERR: begin
				r_last = 1'b1;
				r_err = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer over the shared square root and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= (job.kind == JOB_WALL) ? S_DIFF : S_EMIT;
					end
				end
				S_DIFF: state_q <= S_SQA;
				S_SQA: state_q <= S_SQB;
				S_SQB: state_q <= S_ROOT;
				S_ROOT: begin
					if (bit_q == 64'd1) begin
						state_q <= S_MULB;
					end
				end
				S_MULB: state_q <= (root_q == '0) ? S_EMIT : S_MULA;
				S_MULA: state_q <= S_DLOAD;
				S_DLOAD: state_q <= S_DIV;
				S_DIV: begin
					if (dcnt_q == 5'd31) begin
						state_q <= (div_idx_q == 2'd3) ? S_EMIT : S_DLOAD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					job_q <= job;
				end
			end
			S_DIFF: begin
				dx_q <= dx;
				dy_q <= dy;
				a_q <= halve ? ax[31:1] : ax[30:0];
				b_q <= halve ? ay[31:1] : ay[30:0];
			end
			S_SQA: sq_q <= {2'd0, 62'(a_q * a_q)};
			S_SQB: begin
				rmd_q <= sq_q + {2'd0, 62'(b_q * b_q)};
				root_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			S_ROOT: begin
				if (rmd_q >= root_try) begin
					rmd_q <= rmd_q - root_try;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_MULB: begin
				len_q <= root_q[31:0];
				pb_q <= 62'(b_q * thickness);
				if (root_q == '0) begin
					for (int i = 0; i < 4; i++) begin
						quo_q[i] <= '0;
					end
				end
			end
			S_MULA: begin
				pa_q <= 62'(a_q * thickness);
				div_idx_q <= 2'd0;
			end
			S_DLOAD: begin
				dd_q <= div_idx_q[1] ? {len_q, 1'b0} : {1'b0, len_q};
				dr_q <= {3'd0, num[62:32]};
				dsh_q <= num[31:0];
				dcnt_q <= '0;
			end
			S_DIV: begin
				dr_q <= ge ? trial - {1'b0, dd_q} : trial;
				dsh_q <= {dsh_q[30:0], ge};
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd31) begin
					quo_q[div_idx_q] <= {dsh_q[30:0], ge};
					div_idx_q <= div_idx_q + 2'd1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					center_x <= r_cx;
					center_y <= r_cy;
					center_z <= r_cz;
					axis_a_x <= r_ax;
					axis_a_y <= r_ay;
					axis_b_x <= r_bx;
					axis_b_y <= r_by;
					axis_c_z <= r_cz_axis;
					box_kind <= r_kind;
					last_box <= r_last;
					too_few_vertices <= r_err;
				end
			end
			default: ;
		endcase
	end

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && too_few_vertices |-> last_box)
		else $error("error result not marked as the last box");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> len_q != '0)
		else $error("division started with a zero edge length");

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wpcb_pkg::*;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] cz_axis;
		logic [1:0] kind;
		logic last;
		logic too_few;
	} box_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic last_vertex;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] center_z;
	logic signed [31:0] axis_a_x;
	logic signed [31:0] axis_a_y;
	logic signed [31:0] axis_b_x;
	logic signed [31:0] axis_b_y;
	logic signed [31:0] axis_c_z;
	logic [1:0] box_kind;
	logic last_box;
	logic too_few_vertices;

	// Boxes still owed by the block, oldest first
	box_t boxes_due[$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// Model of the polygon state and the two registers
	longint thick;
	longint height;
	longint first_px, first_py, prev_px, prev_py;
	longint min_px, min_py, max_px, max_py;
	int vertex_count;

	wall_polygon_collision_boxes DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_stall(out_stall),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.axis_a_x(axis_a_x), .axis_a_y(axis_a_y),
		.axis_b_x(axis_b_x), .axis_b_y(axis_b_y), .axis_c_z(axis_c_z),
		.box_kind(box_kind), .last_box(last_box), .too_few_vertices(too_few_vertices)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) begin
			bitv = bitv >> 2;
		end
		while (bitv != 0) begin
			if (s >= r + bitv) begin
				s = s - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic void clear_polygon();
		first_px = 0; first_py = 0; prev_px = 0; prev_py = 0;
		min_px = 64'sd2147483647; min_py = 64'sd2147483647;
		max_px = -64'sd2147483648; max_py = -64'sd2147483648;
		vertex_count = 0;
	endfunction

	// Wall box for the edge from (x0,y0) to (x1,y1), normal scaled by the thickness
	function automatic box_t wall_box(input longint x0, input longint y0,
			input longint x1, input longint y1);
		box_t w;
		longint dx, dy, nx, ny, ox, oy;
		longint unsigned ma, mb, len, t, na, nb, ha, hb;
		dx = x1 - x0;
		dy = y1 - y0;
		ma = (dx < 0) ? -dx : dx;
		mb = (dy < 0) ? -dy : dy;
		t = thick;
		nx = 0; ny = 0; ox = 0; oy = 0;
		if (ma >= 64'h8000_0000 || mb >= 64'h8000_0000) begin
			ma = ma >> 1;
			mb = mb >> 1;
		end
		len = int_sqrt(ma * ma + mb * mb);
		// A zero-length edge leaves the normal and the centre offset at zero
		if (len != 0) begin
			nb = (mb * t + len / 2) / len;
			na = (ma * t + len / 2) / len;
			hb = (mb * t + len) / (2 * len);
			ha = (ma * t + len) / (2 * len);
			nx = (dy < 0) ? longint'(nb) : -longint'(nb);
			ny = (dx < 0) ? -longint'(na) : longint'(na);
			ox = (dy < 0) ? -longint'(hb) : longint'(hb);
			oy = (dx < 0) ? longint'(ha) : -longint'(ha);
		end
		w.cx = clamp32(((x0 + x1) >>> 1) + ox);
		w.cy = clamp32(((y0 + y1) >>> 1) + oy);
		w.cz = clamp32(height >>> 1);
		w.ax = clamp32(dx);
		w.ay = clamp32(dy);
		w.bx = clamp32(nx);
		w.by = clamp32(ny);
		w.cz_axis = clamp32(height);
		w.kind = BOX_WALL;
		w.last = 1'b0;
		w.too_few = 1'b0;
		return w;
	endfunction

	// Floor or ceiling slab over the bounding box grown by the thickness
	function automatic box_t slab_box(input logic [1:0] kind);
		box_t s;
		s.cx = clamp32((min_px + max_px) >>> 1);
		s.cy = clamp32((min_py + max_py) >>> 1);
		s.cz = (kind == BOX_FLOOR) ? clamp32((-thick) >>> 1) : clamp32(height + (thick >>> 1));
		s.ax = clamp32(max_px - min_px + 2 * thick);
		s.ay = '0;
		s.bx = '0;
		s.by = clamp32(max_py - min_py + 2 * thick);
		s.cz_axis = clamp32(thick);
		s.kind = kind;
		s.last = (kind == BOX_CEILING);
		s.too_few = 1'b0;
		return s;
	endfunction

	// Work out the boxes that one accepted vertex causes
	function automatic void predict_boxes(input longint x, input longint y, input logic last);
		box_t e;
		if (x < min_px) min_px = x;
		if (y < min_py) min_py = y;
		if (x > max_px) max_px = x;
		if (y > max_py) max_py = y;
		if (vertex_count == 0) begin
			first_px = x;
			first_py = y;
		end
		if (vertex_count < 3) vertex_count++;
		if (last && vertex_count < 3) begin
			e = '{default: '0};
			e.kind = BOX_WALL;
			e.last = 1'b1;
			e.too_few = 1'b1;
			boxes_due.push_back(e);
			clear_polygon();
			return;
		end
		if (vertex_count >= 2) boxes_due.push_back(wall_box(prev_px, prev_py, x, y));
		prev_px = x;
		prev_py = y;
		if (last) begin
			boxes_due.push_back(wall_box(x, y, first_px, first_py));
			boxes_due.push_back(slab_box(BOX_FLOOR));
			boxes_due.push_back(slab_box(BOX_CEILING));
			clear_polygon();
		end
	endfunction

	// Receiver stalls at random once out of reset
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Compare each result transaction with the oldest box owed
	always @(posedge clk) begin
		box_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (boxes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected box, expected none actual kind %0d", $time, box_kind);
			end else begin
				e = boxes_due.pop_front();
				check_field("center_x", e.cx, center_x);
				check_field("center_y", e.cy, center_y);
				check_field("center_z", e.cz, center_z);
				check_field("axis_a_x", e.ax, axis_a_x);
				check_field("axis_a_y", e.ay, axis_a_y);
				check_field("axis_b_x", e.bx, axis_b_x);
				check_field("axis_b_y", e.by, axis_b_y);
				check_field("axis_c_z", e.cz_axis, axis_c_z);
				check_field("box_kind", e.kind, box_kind);
				check_field("last_box", e.last, last_box);
				check_field("too_few_vertices", e.too_few, too_few_vertices);
			end
		end
	end

	// Send one vertex transaction, at random with a gap beforehand
	task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= x;
		vertex_y <= y;
		last_vertex <= last;
		do @(posedge clk); while (in_stall);
		predict_boxes(x, y, last);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (boxes_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WALL_THICKNESS) thick = val;
		else if (idx == REG_ROOM_HEIGHT) height = val;
	endtask

	function automatic logic signed [31:0] random_coord(input int spread);
		case (spread)
			0: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			1: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_extremes();
		send_vertex(COORD_MIN, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, 1'b1);
		send_vertex(32'sh0001_0000, 32'sh0, 1'b0);
		send_vertex(32'sh0, 32'sh0001_0000, 1'b0);
		send_vertex(-32'sh0001_0000, -32'sh0001_0000, 1'b1);
	endtask

	task automatic test_too_few();
		send_vertex(32'sh0003_0000, -32'sh0002_0000, 1'b1);
		send_vertex(COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, 1'b1);
	endtask

	task automatic test_zero_edge();
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 1'b0);
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 1'b0);
		send_vertex(32'sh0005_0000, 32'sh0001_0000, 1'b0);
		send_vertex(32'sh0002_0000, 32'sh0002_0000, 1'b1);
		send_vertex(32'sh0, 32'sh0, 1'b0);
		send_vertex(32'sh0, 32'sh0, 1'b0);
		send_vertex(32'sh0, 32'sh0, 1'b1);
	endtask

	// Mostly well-formed polygons, some short ones and repeated vertices
	task automatic test_random_polygons(input int vertices);
		int sent;
		int n;
		int spread;
		logic signed [31:0] x, y;
		sent = 0;
		while (sent < vertices) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 3);
			spread = $urandom_range(5);
			spread = (spread < 3) ? 0 : (spread < 5) ? 1 : 2;
			for (int i = 0; i < n; i++) begin
				if (i > 0 && $urandom_range(11) == 0) begin
					x = vertex_x;
					y = vertex_y;
				end else begin
					x = random_coord(spread);
					y = random_coord(spread);
				end
				send_vertex(x, y, i == n - 1);
			end
			sent += n;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		vertex_x <= '0;
		vertex_y <= '0;
		last_vertex <= 1'b0;
		out_stall <= 1'b0;
		thick = WALL_THICKNESS_RESET;
		height = ROOM_HEIGHT_RESET;
		clear_polygon();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_too_few();
		test_zero_edge();

		// Phase with no idling, smallest register values
		write_register(REG_WALL_THICKNESS, 31'd1);
		write_register(REG_ROOM_HEIGHT, 31'd1);
		write_register(2'd3, 31'($urandom));
		test_extremes();
		test_random_polygons(110);

		// Sender mostly idle, largest register values
		write_register(REG_WALL_THICKNESS, 31'h7FFF_FFFF);
		write_register(REG_ROOM_HEIGHT, 31'h7FFF_FFFF);
		write_register(2'd2, 31'($urandom));
		send_idle_pct = 85;
		test_extremes();
		test_random_polygons(110);

		// Receiver mostly stalling, random register values
		write_register(REG_WALL_THICKNESS, 31'($urandom_range(32'h7FFF_FFFF, 1)));
		write_register(REG_ROOM_HEIGHT, 31'($urandom_range(32'h0010_0000, 1)));
		send_idle_pct = 0;
		stall_pct = 85;
		test_random_polygons(110);

		// Both sides idling now and then, ordinary register values
		write_register(REG_WALL_THICKNESS, 31'($urandom_range(32'h0004_0000, 1)));
		write_register(REG_ROOM_HEIGHT, 31'($urandom_range(32'h0040_0000, 1)));
		send_idle_pct = 23;
		stall_pct = 23;
		test_too_few();
		test_random_polygons(110);

		wait_idle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
